### rtl/pid_ta_pkg.sv
// Shared types and constants for the trapezoidal PID controller core.
// Has no dependencies. Every other file in rtl/ imports it.
`default_nettype none

package pid_ta_pkg;

    localparam int GAIN_W    = 16;
    localparam int INTEG_W   = 32;
    localparam int DRIVE_W   = 48;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic signed [DRIVE_W-1:0] t_drive;

    localparam t_cfg_idx CFG_SETPOINT = 2'd0;
    localparam t_cfg_idx CFG_GAIN_P   = 2'd1;
    localparam t_cfg_idx CFG_GAIN_I   = 2'd2;
    localparam t_cfg_idx CFG_GAIN_D   = 2'd3;

endpackage

`default_nettype wire

### rtl/pid_ta_if.sv
// Valid/ready stream interfaces for the sample input and the drive output.
// Depends on pid_ta_pkg for the drive width.
`default_nettype none

interface pid_ta_meas_if #(parameter int SAMPLE_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output measured, input ready);
    modport sink (input valid, input measured, output ready);
endinterface

interface pid_ta_drive_if ();
    import pid_ta_pkg::*;

    logic   valid;
    logic   ready;
    t_drive drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

### rtl/pid_ta_front.sv
// Error stage: error, trapezoidal integral (held doubled, saturating) and error step.
// Depends on pid_ta_pkg. Holds the integral and previous-error state.
`default_nettype none

module pid_ta_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_measured,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_setpoint,
    output logic signed [SAMPLE_WIDTH:0]        o_err,
    output logic signed [SAMPLE_WIDTH+1:0]      o_diff,
    output pid_ta_pkg::t_integ                  o_integ,
    output logic                                o_primed
);
    import pid_ta_pkg::*;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int ISUM_W = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 2;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [ISUM_W-1:0] n_isum;
    t_integ                   n_integ;
    logic [ISUM_W-INTEG_W:0]  isum_top;

    logic signed [ERR_W-1:0]  r_last_err;
    logic                     r_last_valid;
    t_integ                   r_integ;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;

    always_comb begin
        n_err  = ERR_W'(i_setpoint) - ERR_W'(i_measured);
        n_isum = ISUM_W'(r_integ) + ISUM_W'(n_err) + ISUM_W'(r_last_err);
        // The sum fits the integral when its sign bit and all bits above it agree.
        isum_top = n_isum[ISUM_W-1:INTEG_W-1];
        if (isum_top == '0 || isum_top == '1) begin
            n_integ = n_isum[INTEG_W-1:0];
        end else if (n_isum[ISUM_W-1]) begin
            n_integ = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        // No derivative kick on the first sample after reset.
        if (r_last_valid) begin
            n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_err);
        end else begin
            n_diff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err   <= '0;
            r_last_valid <= 1'b0;
            r_integ      <= '0;
        end else if (i_load) begin
            r_last_err   <= n_err;
            r_last_valid <= 1'b1;
            r_integ      <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err  <= n_err;
            r_diff <= n_diff;
        end
    end

    assign o_err    = r_err;
    assign o_diff   = r_diff;
    assign o_integ  = r_integ;
    assign o_primed = r_last_valid;

endmodule

`default_nettype wire

### rtl/pid_ta_mult.sv
// Gain stage: the three gain products, then their rounded sum.
// Depends on pid_ta_pkg. Two register ranks, one per load enable.
`default_nettype none

module pid_ta_mult #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_load_prod,
    input  wire logic                             i_load_sum,
    input  wire pid_ta_pkg::t_gain                i_gain_p,
    input  wire pid_ta_pkg::t_gain                i_gain_i,
    input  wire pid_ta_pkg::t_gain                i_gain_d,
    input  wire logic signed [SAMPLE_WIDTH:0]     i_err,
    input  wire logic signed [SAMPLE_WIDTH+1:0]   i_diff,
    input  wire pid_ta_pkg::t_integ               i_integ,
    output logic signed [((pid_ta_pkg::DRIVE_W > pid_ta_pkg::GAIN_W + SAMPLE_WIDTH + 2)
        ? pid_ta_pkg::DRIVE_W : pid_ta_pkg::GAIN_W + SAMPLE_WIDTH + 2) + 1:0] o_sum
);
    import pid_ta_pkg::*;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int I_W    = GAIN_W + INTEG_W;
    localparam int D_W    = GAIN_W + DIFF_W;
    localparam int SUM_W  = ((DRIVE_W > D_W) ? DRIVE_W : D_W) + 2;

    logic signed [P_W-1:0]   r_p;
    logic signed [I_W-1:0]   r_i;
    logic signed [D_W-1:0]   r_d;
    logic signed [I_W:0]     n_i_half;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_p <= P_W'(i_gain_p) * P_W'(i_err);
            r_i <= I_W'(i_gain_i) * I_W'(i_integ);
            r_d <= D_W'(i_gain_d) * D_W'(i_diff);
        end
    end

    // The integral is doubled, so its term is halved, rounding ties upward.
    always_comb begin
        n_i_half = ((I_W+1)'(r_i) + (I_W+1)'(1)) >>> 1;
        n_sum    = SUM_W'(r_p) + SUM_W'(n_i_half) + SUM_W'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

### rtl/pid_ta_accum.sv
// Output accumulator: adds each step's increment and saturates to the drive range.
// Depends on pid_ta_pkg. The accumulator doubles as the output register.
`default_nettype none

module pid_ta_accum #(
    parameter int INC_W = 50
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire logic signed [INC_W-1:0] i_inc,
    output pid_ta_pkg::t_drive           o_drive
);
    import pid_ta_pkg::*;

    localparam int ASUM_W = ((INC_W > DRIVE_W) ? INC_W : DRIVE_W) + 1;

    logic signed [ASUM_W-1:0] n_asum;
    logic [ASUM_W-DRIVE_W:0]  asum_top;
    t_drive                   n_acc;
    t_drive                   r_acc;

    always_comb begin
        n_asum   = ASUM_W'(r_acc) + ASUM_W'(i_inc);
        asum_top = n_asum[ASUM_W-1:DRIVE_W-1];
        if (asum_top == '0 || asum_top == '1) begin
            n_acc = n_asum[DRIVE_W-1:0];
        end else if (n_asum[ASUM_W-1]) begin
            n_acc = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            n_acc = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_load) begin
            r_acc <= n_acc;
        end
    end

    assign o_drive = r_acc;

endmodule

`default_nettype wire

### rtl/pid_trapezoid_accumulating_core.sv
// Incremental PID controller with a trapezoidal integral. Each accepted sample
// request produces one drive request, the saturated accumulated output in Q40.8.
// The core takes one sample per clock cycle while the output is not stalled; each
// sample passes through five register ranks: input, error/integral, products,
// increment sum, accumulator. The rate is set by the two feedback loops, the
// integral update and the accumulator update, each a single add with saturation.
// Every rank stalls only when it is full and the rank after it cannot move, so
// bubbles are absorbed while the output waits. The user must write configuration
// registers via the plain write port only while the core is idle (not enforced).
// Depends on pid_ta_pkg, pid_ta_if, pid_ta_front, pid_ta_mult and pid_ta_accum.
`default_nettype none

module pid_trapezoid_accumulating_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    pid_ta_meas_if.sink                     i_meas,
    pid_ta_drive_if.source                  o_drive,
    input  wire logic                       i_cfg_we,
    input  wire pid_ta_pkg::t_cfg_idx       i_cfg_index,
    input  wire logic [((SAMPLE_WIDTH > pid_ta_pkg::GAIN_W)
        ? SAMPLE_WIDTH : pid_ta_pkg::GAIN_W)-1:0] i_cfg_data
);
    import pid_ta_pkg::*;

    localparam int D_W   = GAIN_W + SAMPLE_WIDTH + 2;
    localparam int SUM_W = ((DRIVE_W > D_W) ? DRIVE_W : D_W) + 2;

    // Configuration registers.
    logic signed [SAMPLE_WIDTH-1:0] r_setpoint;
    t_gain                          r_gain_p;
    t_gain                          r_gain_i;
    t_gain                          r_gain_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SETPOINT: r_setpoint <= i_cfg_data[SAMPLE_WIDTH-1:0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Rank valid bits and the ready chain, from the output back to the input.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic ld0, ld1, ld2, ld3, ld4;

    assign rdy4 = !r_v4 || o_drive.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign ld0 = i_meas.valid && rdy0;
    assign ld1 = r_v0 && rdy1;
    assign ld2 = r_v1 && rdy2;
    assign ld3 = r_v2 && rdy3;
    assign ld4 = r_v3 && rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_meas.valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Input register.
    logic signed [SAMPLE_WIDTH-1:0] r_meas;

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_meas <= i_meas.measured;
        end
    end

    logic signed [SAMPLE_WIDTH:0]   err;
    logic signed [SAMPLE_WIDTH+1:0] diff;
    t_integ                         integ;
    logic                           primed;
    logic signed [SUM_W-1:0]        inc;
    t_drive                         drive;

    pid_ta_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld1),
        .i_measured (r_meas),
        .i_setpoint (r_setpoint),
        .o_err      (err),
        .o_diff     (diff),
        .o_integ    (integ),
        .o_primed   (primed)
    );

    pid_ta_mult #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mult (
        .i_clk       (i_clk),
        .i_load_prod (ld2),
        .i_load_sum  (ld3),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_err       (err),
        .i_diff      (diff),
        .i_integ     (integ),
        .o_sum       (inc)
    );

    pid_ta_accum #(
        .INC_W (SUM_W)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld4),
        .i_inc   (inc),
        .o_drive (drive)
    );

    assign i_meas.ready  = rdy0;
    assign o_drive.valid = r_v4;
    assign o_drive.drive = drive;

    // After reset the input, increment-sum and output ranks hold no pending result.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v4 && !r_v3 && !r_v0)
        else $error("output or pipeline valid set right after reset");

    // The accumulator only moves when a step enters the output rank.
    a_drive_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ld4 |=> $stable(drive))
        else $error("drive changed without a step entering the output rank");

    // Once a sample reaches the error stage, later samples get a derivative term.
    a_primed_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld1 |=> primed)
        else $error("previous-error state not marked valid after a step");

    // A waiting result is never overwritten by a later step.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !o_drive.ready) |-> !ld4)
        else $error("output rank loaded while its result was still waiting");

endmodule

`default_nettype wire
